### src/tgcc_pkg.sv
// Thai glyph cluster composer: shared types, code constants and lookup functions.
// No dependencies; imported by the composer top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package tgcc_pkg;

	localparam logic [15:0] MAP_OFF       = 16'h0D60;
	localparam logic [15:0] CODE_AM       = 16'h0E33;
	localparam logic [15:0] CODE_NIKHAHIT = 16'h0E4D;
	localparam logic [15:0] CODE_AA       = 16'h0E32;
	localparam logic [15:0] TONE_LO       = 16'h0E48;
	localparam logic [15:0] TONE_HI       = 16'h0E4B;
	localparam logic [7:0]  BASE_OFF      = 8'hA0;
	localparam logic [7:0]  MARK_ED       = 8'hED;
	localparam logic [7:0]  BASE_REF_LO   = 8'hAD;
	localparam logic [7:0]  BASE_REF_HI   = 8'hB0;
	localparam logic [15:0] REF_LO        = 16'h8000;
	localparam logic [15:0] REF_HI        = 16'h8100;
	localparam logic [7:0]  BELOW_GLYPH   = 8'h38;
	localparam logic [7:0]  BELOW_FIRST   = 8'hD8;
	localparam int          RES_DEPTH     = 5;

	typedef enum logic [2:0] {
		OP_BASE    = 3'd0,
		OP_REPLACE = 3'd1,
		OP_MARK    = 3'd2,
		OP_CLOSE   = 3'd3,
		OP_INVALID = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] glyph;
		logic [7:0] chars;
		logic       invalid_mark;
		logic       last;
	} res_t;

	function automatic res_t mk_res(op_t op, logic [7:0] glyph, logic [7:0] chars,
		logic invalid_mark);
		res_t r;
		r.op           = op;
		r.glyph        = glyph;
		r.chars        = chars;
		r.invalid_mark = invalid_mark;
		r.last         = 1'b0;
		return r;
	endfunction

	// Thai unit to 8-bit code; zero for anything outside 0E01..0E3A and 0E3F..0E5B.
	function automatic logic [7:0] map_code(logic [15:0] u, logic am_as_mark);
		logic [15:0] t;
		t = u;
		if ((u >= 16'h0E01 && u <= 16'h0E3A) || (u >= 16'h0E3F && u <= 16'h0E5B)) begin
			if (u == CODE_AM)
				t = am_as_mark ? CODE_NIKHAHIT : CODE_AA;
			return 8'(t - MAP_OFF);
		end
		return 8'h00;
	endfunction

	function automatic logic is_mark(logic [7:0] c);
		return c == 8'hD1 || (c >= 8'hD4 && c <= 8'hDA) || (c >= 8'hE7 && c <= 8'hEE);
	endfunction

	// Returns {reference glyph, mark glyph}; all zero when the mark has no glyph.
	function automatic logic [15:0] mark_glyph(logic [7:0] c, logic [7:0] base,
		logic [7:0] prev);
		logic [31:0] row;
		logic [1:0]  sel;
		logic [15:0] v;
		row = '0;
		sel = '0;
		v   = '0;
		if (c == 8'hD8 || c == 8'hD9 || c == 8'hDA) begin
			if (base == BASE_REF_LO)
				v = REF_LO;
			else if (base == BASE_REF_HI)
				v = REF_HI;
			v[7:0] = 8'(BELOW_GLYPH + (c - BELOW_FIRST));
			return v;
		end
		// rows hold glyphs for selections 3..0, high byte first
		unique case (c)
			8'hD1: row = 32'h0000_6031;
			8'hD4: row = 32'h0000_6134;
			8'hD5: row = 32'h0000_6235;
			8'hD6: row = 32'h0000_6336;
			8'hD7: row = 32'h0000_6437;
			8'hE7: row = 32'h0000_6547;
			8'hE8: row = 32'h7870_6848;
			8'hE9: row = 32'h7971_6949;
			8'hEA: row = 32'h7A72_6A4A;
			8'hEB: row = 32'h7B73_6B4B;
			8'hEC: row = 32'h7C74_6C4C;
			8'hED: row = 32'h0000_6D4D;
			8'hEE: row = 32'h0000_6E4E;
			default: row = '0;
		endcase
		if (base == 8'hBB || base == 8'hBD || base == 8'hBF || base == 8'hCB)
			sel[0] = 1'b1;
		if (prev == 8'hD1 || (prev >= 8'hD4 && prev <= 8'hD7) || prev == 8'hE7 ||
			prev == 8'hED)
			sel[1] = 1'b1;
		v[7:0] = row[{sel, 3'b000} +: 8];
		return v;
	endfunction

endpackage

`default_nettype wire

### src/tgcc_in_if.sv
// Request channel of the Thai glyph cluster composer: code unit and lookahead.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tgcc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code;
	logic [15:0] next_code;

	modport source (output valid, output code, output next_code, input ready);
	modport sink   (input valid, input code, input next_code, output ready);
endinterface

`default_nettype wire

### src/tgcc_out_if.sv
// Result channel of the Thai glyph cluster composer: one glyph operation per item.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tgcc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] glyph;
	logic [7:0] chars;
	logic       invalid_mark;
	logic       last;

	modport source (output valid, output op, output glyph, output chars,
		output invalid_mark, output last, input ready);
	modport sink   (input valid, input op, input glyph, input chars,
		input invalid_mark, input last, output ready);
endinterface

`default_nettype wire

### src/thai_glyph_cluster_composer_unit.sv
// Top level of the Thai glyph cluster composer.
// Depends on tgcc_pkg, tgcc_in_if and tgcc_out_if.
`timescale 1ns / 1ps
`default_nettype none

// Composes Thai UTF-16 code units into glyph cells. Each request carries one code
// unit and its lookahead and yields zero to three glyph operations (new cell,
// replace cell, OR mark, cluster closed, invalid start), the final one flagged by
// last. All decoding for a request happens in one pass of logic at the accepting
// edge; its operations are loaded into a five-entry result buffer and leave it one
// per cycle while result.ready holds. A request holds the result port until all its
// operations (at most three) are taken: the next request is taken in the same
// cycle that the final operation of the previous one is taken, or at once when it
// had none, so requests of one operation flow at one per cycle when result is ready.
module thai_glyph_cluster_composer_unit
	import tgcc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	tgcc_in_if.sink     item,
	tgcc_out_if.source  result
);

	// cluster state
	logic       in_cluster_q;
	logic [7:0] base_code_q;
	logic [7:0] prev_mark_q;
	logic [7:0] char_count_q;

	// result buffer: entry 0 is on the port
	res_t       res_q [RES_DEPTH];
	logic [2:0] rem_q;

	// next-state and result list for the request on the port
	res_t       list [RES_DEPTH];
	logic [2:0] n;
	logic       nx_in_cluster;
	logic [7:0] nx_base, nx_prev, nx_count;
	logic [7:0] c, sc;
	logic [15:0] v1, v2;
	logic       ok, do_close, do_start;

	logic accept, pop;

	assign pop    = result.valid && result.ready;
	// take a request when nothing is pending or the final operation leaves now
	assign item.ready = (rem_q == 3'd0) || (rem_q == 3'd1 && result.ready);
	assign accept = item.valid && item.ready;

	always_comb begin
		for (int i = 0; i < RES_DEPTH; i++)
			list[i] = '0;
		n             = '0;
		nx_in_cluster = in_cluster_q;
		nx_base       = base_code_q;
		nx_prev       = prev_mark_q;
		nx_count      = char_count_q;
		c             = map_code(item.code, 1'b1);
		sc            = map_code(item.code, 1'b0);
		v1            = '0;
		v2            = '0;
		ok            = (c != 8'h00);
		do_close      = 1'b0;
		do_start      = 1'b0;

		if (!in_cluster_q) begin
			do_start = 1'b1;
		end else if (item.code == 16'h0000) begin
			// end of text closes the open cluster
			do_close = 1'b1;
		end else begin
			// a tone mark before nikhahit or sara am takes the nikhahit first
			if (ok && item.code >= TONE_LO && item.code <= TONE_HI &&
				(item.next_code == CODE_NIKHAHIT || item.next_code == CODE_AM)) begin
				v1 = mark_glyph(MARK_ED, base_code_q, nx_prev);
				if (v1 == 16'h0000) begin
					ok = 1'b0;
				end else begin
					if (v1[15:8] != 8'h00 && n < 3'(RES_DEPTH)) begin
						list[n] = mk_res(OP_REPLACE, v1[15:8], 8'h00, 1'b0);
						n = n + 3'd1;
					end
					if (n < 3'(RES_DEPTH)) begin
						list[n] = mk_res(OP_MARK, v1[7:0], 8'h00, 1'b0);
						n = n + 3'd1;
					end
					nx_prev = MARK_ED;
				end
			end
			if (ok) begin
				v2 = mark_glyph(c, base_code_q, nx_prev);
				if (v2 == 16'h0000) begin
					ok = 1'b0;
				end else begin
					if (v2[15:8] != 8'h00 && n < 3'(RES_DEPTH)) begin
						list[n] = mk_res(OP_REPLACE, v2[15:8], 8'h00, 1'b0);
						n = n + 3'd1;
					end
					if (n < 3'(RES_DEPTH)) begin
						list[n] = mk_res(OP_MARK, v2[7:0], 8'h00, 1'b0);
						n = n + 3'd1;
					end
					nx_prev = c;
				end
			end
			if (!ok || item.code == CODE_AM) begin
				// the unit cannot join, or sara am: close and restart on it
				do_close = 1'b1;
				do_start = 1'b1;
			end else if (char_count_q != 8'hFF) begin
				nx_count = char_count_q + 8'd1;
			end
		end

		if (do_close) begin
			if (n < 3'(RES_DEPTH)) begin
				list[n] = mk_res(OP_CLOSE, 8'h00, char_count_q, 1'b0);
				n = n + 3'd1;
			end
			nx_in_cluster = 1'b0;
		end

		if (do_start && item.code != 16'h0000 && n < 3'(RES_DEPTH)) begin
			if (sc == 8'h00) begin
				list[n] = mk_res(OP_INVALID, 8'h00, 8'h00, 1'b0);
			end else if (is_mark(sc)) begin
				list[n] = mk_res(OP_INVALID, 8'h00, 8'h00, 1'b1);
			end else begin
				list[n] = mk_res(OP_BASE, 8'(sc - BASE_OFF), 8'h00, 1'b0);
				nx_in_cluster = 1'b1;
				nx_base       = sc;
				nx_prev       = sc;
				nx_count      = 8'd1;
			end
			n = n + 3'd1;
		end

		// flag the final operation of this request
		if (n != 3'd0)
			list[n - 3'd1].last = 1'b1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cluster_q <= 1'b0;
			base_code_q  <= '0;
			prev_mark_q  <= '0;
			char_count_q <= '0;
			rem_q        <= '0;
		end else begin
			if (accept) begin
				in_cluster_q <= nx_in_cluster;
				base_code_q  <= nx_base;
				prev_mark_q  <= nx_prev;
				char_count_q <= nx_count;
				rem_q        <= n;
			end else if (pop) begin
				rem_q <= rem_q - 3'd1;
			end
		end
	end

	// result payload: load on accept, advance on pop
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < RES_DEPTH; i++)
				res_q[i] <= list[i];
		end else if (pop) begin
			for (int i = 0; i < RES_DEPTH - 1; i++)
				res_q[i] <= res_q[i + 1];
		end
	end

	assign result.valid        = (rem_q != 3'd0);
	assign result.op           = res_q[0].op;
	assign result.glyph        = res_q[0].glyph;
	assign result.chars        = res_q[0].chars;
	assign result.invalid_mark = res_q[0].invalid_mark;
	assign result.last         = res_q[0].last;

endmodule

`default_nettype wire

### src/tgcc_checker.sv
// Port-level checks for the Thai glyph cluster composer, bound to the top level.
// Depends on tgcc_pkg and thai_glyph_cluster_composer_unit.
`timescale 1ns / 1ps
`default_nettype none

module tgcc_checker
	import tgcc_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       item_ready,
	input wire       res_valid,
	input wire       res_ready,
	input wire [2:0] res_op,
	input wire [7:0] res_glyph,
	input wire [7:0] res_chars,
	input wire       res_invalid_mark,
	input wire       res_last
);

	// a new request is taken only once the previous one has drained
	a_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !res_valid || (res_ready && res_last))
		else $error("request taken while results still pending");

	// a closed cluster always held at least its base
	a_close_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_op == OP_CLOSE |-> res_chars != 8'h00 && res_glyph == 8'h00)
		else $error("cluster close with bad count or glyph");

	// only an invalid start may carry the mark flag
	a_mark_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_op != OP_INVALID |-> !res_invalid_mark)
		else $error("invalid_mark set outside invalid start");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_op) && $stable(res_glyph) &&
			$stable(res_chars) && $stable(res_last))
		else $error("stalled result changed");

endmodule

bind thai_glyph_cluster_composer_unit tgcc_checker u_tgcc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_ready       (item.ready),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.res_op           (result.op),
	.res_glyph        (result.glyph),
	.res_chars        (result.chars),
	.res_invalid_mark (result.invalid_mark),
	.res_last         (result.last)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for thai_glyph_cluster_composer_unit: a directed table and
// random words, checked against typed rows or an in-bench composer model.
// Depends on tgcc_pkg, tgcc_in_if, tgcc_out_if and the composer top level.

module tb_top;
	import tgcc_pkg::*;

	// One row of the directed table. Rows with typed set carry their expected
	// operation by hand (zero or one of them); all others are left to the model.
	typedef struct packed {
		logic [15:0] code;
		logic [15:0] nxt;
		logic        typed;
		logic        has_op;
		res_t        op;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tgcc_in_if  req_if ();
	tgcc_out_if res_if ();

	thai_glyph_cluster_composer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_if),
		.result (res_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Composer model state: open flag, base, last applied mark, unit count.
	logic       cl_open  = 1'b0;
	logic [7:0] cl_base  = 8'h00;
	logic [7:0] cl_prev  = 8'h00;
	logic [7:0] cl_count = 8'h00;

	// Operations of the request being predicted, then the queue of pending ones.
	res_t step_ops [5];
	int   step_n;
	res_t glyph_ops_q [$];

	logic quiet = 1'b0;   // when set, neither side idles
	int   n_requests = 0;
	int   n_results  = 0;
	int   n_closed   = 0;
	int   n_invalid  = 0;
	int   n_refs     = 0;
	int   n_errors   = 0;

	// ---------------------------------------------------------------------
	// Composer model
	// ---------------------------------------------------------------------

	// Thai unit to its 8-bit code, zero outside 0E01..0E3A and 0E3F..0E5B. Sara am
	// reads as nikhahit inside a cluster and as sara aa at a cluster start.
	function automatic logic [7:0] thai_map(logic [15:0] u, logic in_cell);
		if (u == CODE_AM)
			return in_cell ? 8'(CODE_NIKHAHIT - MAP_OFF) : 8'(CODE_AA - MAP_OFF);
		if ((u >= 16'h0E01 && u <= 16'h0E3A) || (u >= 16'h0E3F && u <= 16'h0E5B))
			return 8'(u - MAP_OFF);
		return 8'h00;
	endfunction

	function automatic logic is_combining(logic [7:0] c);
		return c == 8'hD1 || (c >= 8'hD4 && c <= 8'hDA) || (c >= 8'hE7 && c <= 8'hEE);
	endfunction

	// Marks that sit above the consonant and push the next mark higher.
	function automatic logic is_upper(logic [7:0] c);
		return c == 8'hD1 || (c >= 8'hD4 && c <= 8'hD7) || c == 8'hE7 || c == 8'hED;
	endfunction

	// Consonants with a tall ascender: marks shift left over them.
	function automatic logic is_tall(logic [7:0] b);
		return b == 8'hBB || b == 8'hBD || b == 8'hBF || b == 8'hCB;
	endfunction

	// {reference glyph, mark glyph} for mark c on this cell, zero if it cannot join.
	function automatic logic [15:0] cell_glyph(logic [7:0] c, logic [7:0] b, logic [7:0] p);
		logic [1:0] sel;
		logic [7:0] ref_g;
		logic [7:0] g;
		sel   = {is_upper(p), is_tall(b)};
		ref_g = 8'h00;
		g     = 8'h00;
		if (c >= 8'hD8 && c <= 8'hDA) begin
			// below vowels: yo ying and tho than lose their lower tail first
			if (b == 8'hAD)
				ref_g = 8'h80;
			else if (b == 8'hB0)
				ref_g = 8'h81;
			g = 8'h38 + (c - 8'hD8);
		end else if (c >= 8'hE8 && c <= 8'hEC) begin
			// tone marks and thanthakhat have all four placements
			case (sel)
				2'd0: g = 8'h48 + (c - 8'hE8);
				2'd1: g = 8'h68 + (c - 8'hE8);
				2'd2: g = 8'h70 + (c - 8'hE8);
				default: g = 8'h78 + (c - 8'hE8);
			endcase
		end else if (!sel[1]) begin
			// other marks cannot stack over an upper mark
			case (c)
				8'hD1: g = sel[0] ? 8'h60 : 8'h31;
				8'hD4, 8'hD5, 8'hD6, 8'hD7:
					g = sel[0] ? 8'h61 + (c - 8'hD4) : 8'h34 + (c - 8'hD4);
				8'hE7: g = sel[0] ? 8'h65 : 8'h47;
				8'hED: g = sel[0] ? 8'h6D : 8'h4D;
				8'hEE: g = sel[0] ? 8'h6E : 8'h4E;
				default: g = 8'h00;
			endcase
		end
		return (g == 8'h00) ? 16'h0000 : {ref_g, g};
	endfunction

	function automatic void add_op(op_t op, logic [7:0] glyph, logic [7:0] chars,
		logic mark);
		if (step_n < 5) begin
			step_ops[step_n].op           = op;
			step_ops[step_n].glyph        = glyph;
			step_ops[step_n].chars        = chars;
			step_ops[step_n].invalid_mark = mark;
			step_ops[step_n].last         = 1'b0;
			step_n++;
		end
	endfunction

	// Apply one mark to the open cell; report whether it fitted.
	function automatic logic lay_mark(logic [7:0] c);
		logic [15:0] v;
		v = cell_glyph(c, cl_base, cl_prev);
		if (v == 16'h0000)
			return 1'b0;
		if (v[15:8] != 8'h00)
			add_op(OP_REPLACE, v[15:8], 8'h00, 1'b0);
		add_op(OP_MARK, v[7:0], 8'h00, 1'b0);
		cl_prev = c;
		return 1'b1;
	endfunction

	function automatic void close_cell();
		add_op(OP_CLOSE, 8'h00, cl_count, 1'b0);
		cl_open = 1'b0;
	endfunction

	function automatic void open_cell(logic [15:0] code);
		logic [7:0] c;
		if (code == 16'h0000)
			return;
		c = thai_map(code, 1'b0);
		if (c == 8'h00)
			add_op(OP_INVALID, 8'h00, 8'h00, 1'b0);
		else if (is_combining(c))
			add_op(OP_INVALID, 8'h00, 8'h00, 1'b1);
		else begin
			add_op(OP_BASE, c - BASE_OFF, 8'h00, 1'b0);
			cl_open  = 1'b1;
			cl_base  = c;
			cl_prev  = c;
			cl_count = 8'd1;
		end
	endfunction

	// Work out the operations one request causes into step_ops and advance the model.
	function automatic void predict_request(logic [15:0] code, logic [15:0] nxt);
		logic [7:0] c;
		logic       ok;
		step_n = 0;
		if (!cl_open)
			open_cell(code);
		else if (code == 16'h0000)
			close_cell();
		else begin
			c  = thai_map(code, 1'b1);
			ok = (c != 8'h00);
			// a tone ahead of sara am or nikhahit gets the nikhahit laid under it first
			if (ok && code >= TONE_LO && code <= TONE_HI &&
				(nxt == CODE_NIKHAHIT || nxt == CODE_AM))
				ok = lay_mark(MARK_ED);
			if (ok)
				ok = lay_mark(c);
			// a unit that does not fit, and sara am always, restarts the cluster
			if (!ok || code == CODE_AM) begin
				close_cell();
				open_cell(code);
			end else if (cl_count != 8'hFF)
				cl_count++;
		end
		if (step_n > 0)
			step_ops[step_n - 1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic res_t single_op(op_t op, logic [7:0] glyph, logic [7:0] chars,
		logic mark);
		res_t r;
		r.op           = op;
		r.glyph        = glyph;
		r.chars        = chars;
		r.invalid_mark = mark;
		r.last         = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t plain_row(logic [15:0] code, logic [15:0] nxt);
		stim_row_t r;
		r        = '0;
		r.code   = code;
		r.nxt    = nxt;
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [15:0] code, logic [15:0] nxt,
		logic has_op, res_t op);
		stim_row_t r;
		r        = plain_row(code, nxt);
		r.typed  = 1'b1;
		r.has_op = has_op;
		r.op     = op;
		return r;
	endfunction

	function automatic int draw_gap();
		if (quiet)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// Mark-like units, sara am included; tones weighted up.
	function automatic logic [15:0] pick_mark();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return 16'h0E31;
		if (k <= 7)
			return 16'(16'h0E33 + k);
		if (k <= 15)
			return 16'(16'h0E3F + k);
		if (k == 16)
			return CODE_AM;
		return 16'(TONE_LO + $urandom_range(0, 3));
	endfunction

	// Mostly plain consonants, some special bases, some arbitrary Thai units.
	function automatic logic [15:0] pick_start();
		int k;
		k = $urandom_range(0, 9);
		if (k < 6)
			return 16'($urandom_range(16'h0E01, 16'h0E2E));
		if (k < 8)
			case ($urandom_range(0, 5))
				0: return 16'h0E0D;
				1: return 16'h0E10;
				2: return 16'h0E1B;
				3: return 16'h0E1D;
				4: return 16'h0E1F;
				default: return 16'h0E2B;
			endcase
		return 16'($urandom_range(16'h0E01, 16'h0E5B));
	endfunction

	// Present one request after a random gap, hold it until taken, then predict.
	task automatic send_request(input stim_row_t r);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.code      <= r.code;
		req_if.next_code <= r.nxt;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		predict_request(r.code, r.nxt);
		if (r.typed) begin
			if (r.has_op)
				glyph_ops_q.push_back(r.op);
		end else begin
			for (int i = 0; i < step_n; i++)
				glyph_ops_q.push_back(step_ops[i]);
		end
		n_requests++;
	endtask

	// Drop valid and hold off until every pending operation has come out.
	task automatic drain_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (glyph_ops_q.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Result side: random back-pressure and checking
	// ---------------------------------------------------------------------

	initial begin : result_sink
		int stall;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = draw_gap();
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (res_if.valid !== 1'b1);
		end
	end

	// Compare every taken operation, field by field, with the oldest prediction.
	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			got.op           = op_t'(res_if.op);
			got.glyph        = res_if.glyph;
			got.chars        = res_if.chars;
			got.invalid_mark = res_if.invalid_mark;
			got.last         = res_if.last;
			if (glyph_ops_q.size() == 0) begin
				n_errors++;
				$display("%0t ns: unexpected op %0d glyph %02h chars %0d mark %0b last %0b",
					$time, got.op, got.glyph, got.chars, got.invalid_mark, got.last);
			end else begin
				want = glyph_ops_q.pop_front();
				n_results++;
				if (got.op !== want.op || got.glyph !== want.glyph ||
					got.chars !== want.chars || got.invalid_mark !== want.invalid_mark ||
					got.last !== want.last) begin
					n_errors++;
					$display("%0t ns: expected op %0d glyph %02h chars %0d mark %0b last %0b",
						$time, want.op, want.glyph, want.chars, want.invalid_mark, want.last);
					$display("%0t ns: actual   op %0d glyph %02h chars %0d mark %0b last %0b",
						$time, got.op, got.glyph, got.chars, got.invalid_mark, got.last);
				end
				if (want.op == OP_CLOSE)
					n_closed++;
				if (want.op == OP_INVALID)
					n_invalid++;
				if (want.op == OP_REPLACE)
					n_refs++;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------

	initial begin : stimulus
		stim_row_t   dir_tab [$];
		logic [15:0] word [$];
		logic [15:0] nxt;
		int          n_random;
		int          next_flip;
		int          kind;
		logic        drained_mid;

		req_if.valid     = 1'b0;
		req_if.code      = 16'h0000;
		req_if.next_code = 16'h0000;
		arst_n           = 1'b0;
		n_random         = 0;
		next_flip        = 40;
		drained_mid      = 1'b0;

		// hold reset, then release it away from the rising edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. Most rows take the unit of the following row as their
		// lookahead so the rows read as real text.
		// end of text while idle: nothing comes out
		dir_tab.push_back(typed_row(16'h0000, 16'h0000, 1'b0, '0));
		// all-ones unit while idle: not Thai
		dir_tab.push_back(typed_row(16'hFFFF, 16'hFFFF, 1'b1,
			single_op(OP_INVALID, 8'h00, 8'h00, 1'b0)));
		// mai han-akat cannot start a cluster
		dir_tab.push_back(typed_row(16'h0E31, 16'h0000, 1'b1,
			single_op(OP_INVALID, 8'h00, 8'h00, 1'b1)));
		// ko kai opens a cluster with base glyph 01
		dir_tab.push_back(typed_row(16'h0E01, 16'h0E48, 1'b1,
			single_op(OP_BASE, 8'h01, 8'h00, 1'b0)));
		// tone ahead of nikhahit: nikhahit laid first
		dir_tab.push_back(plain_row(16'h0E48, 16'h0E4D));
		dir_tab.push_back(plain_row(16'h0E4D, 16'h0000));
		// end of text inside a cluster closes it
		dir_tab.push_back(plain_row(16'h0000, 16'h0000));
		// tall base, upper vowel, then a tone whose nikhahit cannot fit
		dir_tab.push_back(plain_row(16'h0E1B, 16'h0E34));
		dir_tab.push_back(plain_row(16'h0E34, 16'h0E48));
		dir_tab.push_back(plain_row(16'h0E48, 16'h0E33));
		// sara am while idle starts as sara aa
		dir_tab.push_back(typed_row(16'h0E33, 16'h0E33, 1'b1,
			single_op(OP_BASE, 8'h32, 8'h00, 1'b0)));
		// sara am inside a cluster: nikhahit, close uncounted, restart
		dir_tab.push_back(plain_row(16'h0E33, 16'h0E0D));
		// yo ying and tho than take a reference glyph before a below vowel
		dir_tab.push_back(plain_row(16'h0E0D, 16'h0E38));
		dir_tab.push_back(plain_row(16'h0E38, 16'h0E10));
		dir_tab.push_back(plain_row(16'h0E10, 16'h0E39));
		dir_tab.push_back(plain_row(16'h0E39, 16'h0E3A));
		dir_tab.push_back(plain_row(16'h0E3A, 16'h0041));
		// non-Thai inside a cluster: close then invalid start
		dir_tab.push_back(plain_row(16'h0041, 16'h0E5B));
		// highest Thai unit as a base, then the lowest of the upper range
		dir_tab.push_back(plain_row(16'h0E5B, 16'h0E3F));
		dir_tab.push_back(plain_row(16'h0E3F, 16'h0E3B));
		// unit in the gap of the Thai block counts as non-Thai
		dir_tab.push_back(plain_row(16'h0E3B, 16'h0E2B));
		// tall base, tone ahead of sara am, then sara am itself
		dir_tab.push_back(plain_row(16'h0E2B, 16'h0E4B));
		dir_tab.push_back(plain_row(16'h0E4B, 16'h0E33));
		dir_tab.push_back(plain_row(16'h0E33, 16'h8000));
		dir_tab.push_back(plain_row(16'h8000, 16'h0000));

		foreach (dir_tab[i])
			send_request(dir_tab[i]);
		drain_results();

		// Random words: mostly well-formed clusters with random marks, some noise,
		// some end-of-text. Lookahead follows the word, now and then corrupted.
		while (n_random < 140) begin
			if (n_random >= next_flip) begin
				quiet     = ~quiet;
				next_flip = next_flip + $urandom_range(20, 50);
			end
			word.delete();
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				word.push_back(pick_start());
				repeat ($urandom_range(0, 4))
					word.push_back(pick_mark());
				if ($urandom_range(0, 3) == 0)
					word.push_back(CODE_AM);
			end else if (kind < 9) begin
				repeat ($urandom_range(1, 3))
					word.push_back(($urandom_range(0, 1) != 0) ? 16'($urandom) :
						16'(16'h0E00 + $urandom_range(0, 127)));
			end else
				word.push_back(16'h0000);
			for (int i = 0; i < word.size(); i++) begin
				if (i + 1 < word.size())
					nxt = word[i + 1];
				else
					nxt = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'h0000;
				if ($urandom_range(0, 9) == 0)
					nxt = 16'($urandom);
				send_request(plain_row(word[i], nxt));
				if (word[i] != 16'h0000)
					n_random++;
			end
			// pause the sender once mid-run until the pipe is empty
			if (!drained_mid && n_random >= 70) begin
				drain_results();
				drained_mid = 1'b1;
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (glyph_ops_q.size() != 0) begin
			n_errors += glyph_ops_q.size();
			$display("%0t ns: %0d operations never arrived", $time, glyph_ops_q.size());
		end

		$display("Ran %0d requests (directed rows, then random words);",
			n_requests);
		$display("checked %0d operations: %0d closes, %0d invalid starts, %0d cell refs",
			n_results, n_closed, n_invalid, n_refs);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
